// ----- hw/rtl/ptsd_pkg.sv -----
// Package for the packed token stream decoder.
// Holds the shared types, codes and helper functions; no dependencies.
package ptsd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_GATHER = 2'd1,
    PH_STR    = 2'd2,
    PH_ELEM   = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    PT_NONE   = 4'd0,
    PT_INT8   = 4'd1,
    PT_INT16  = 4'd2,
    PT_INT32  = 4'd3,
    PT_INT64  = 4'd4,
    PT_ARR16  = 4'd5,
    PT_ARR32  = 4'd6,
    PT_ARR64  = 4'd7,
    PT_STR8   = 4'd8,
    PT_STR16  = 4'd9,
    PT_STR32  = 4'd10,
    PT_SINGLE = 4'd11,
    PT_DOUBLE = 4'd12
  } ptype_e;

  typedef enum logic [3:0] {
    CL_POSINT,
    CL_NEGINT,
    CL_ARRFIX,
    CL_STRFIX,
    CL_NIL,
    CL_FALSE,
    CL_TRUE,
    CL_FLOAT,
    CL_GATHER,
    CL_BAD
  } class_e;

  typedef enum logic [3:0] {
    TK_INT      = 4'd0,
    TK_NIL      = 4'd1,
    TK_BOOL     = 4'd2,
    TK_ARR_HDR  = 4'd3,
    TK_STR_HDR  = 4'd4,
    TK_STR_BYTE = 4'd5,
    TK_ELEMENT  = 4'd6,
    TK_BAD_TYPE = 4'd7,
    TK_MISFLOAT = 4'd8
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    class_e     cls;
    ptype_e     pt;
  } qentry_t;

  function automatic logic [3:0] field_size(input ptype_e pt);
    logic [3:0] s;
    case (pt)
      PT_NONE:   s = 4'd0;
      PT_INT8:   s = 4'd1;
      PT_INT16:  s = 4'd2;
      PT_INT32:  s = 4'd4;
      PT_INT64:  s = 4'd8;
      PT_ARR16:  s = 4'd2;
      PT_ARR32:  s = 4'd4;
      PT_ARR64:  s = 4'd8;
      PT_STR8:   s = 4'd1;
      PT_STR16:  s = 4'd2;
      PT_STR32:  s = 4'd4;
      PT_SINGLE: s = 4'd4;
      PT_DOUBLE: s = 4'd8;
      default:   s = 4'd1;
    endcase
    return s;
  endfunction

  function automatic logic [63:0] sign_extend(input logic [63:0] v, input logic [3:0] size);
    logic [63:0] r;
    case (size)
      4'd1:    r = {{56{v[7]}}, v[7:0]};
      4'd2:    r = {{48{v[15]}}, v[15:0]};
      4'd4:    r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] widen_single(input logic [31:0] f);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  p;
    logic [22:0] norm;
    logic [63:0] r;
    s = f[31];
    e = f[30:23];
    m = f[22:0];
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) begin
        p = 5'(i);
      end
    end
    norm = m << (5'd22 - p);
    if (e == 8'hff) begin
      if (m == 23'd0) begin
        r = {s, 11'h7ff, 52'd0};
      end else begin
        r = {s, 11'h7ff, 1'b1, m[21:0], 29'd0};
      end
    end else if (e == 8'd0) begin
      if (m == 23'd0) begin
        r = {s, 63'd0};
      end else begin
        r = {s, 11'({6'd0, p} + 11'd874), norm[21:0], 30'd0};
      end
    end else begin
      r = {s, 11'({3'd0, e} + 11'd896), m, 29'd0};
    end
    return r;
  endfunction

  function automatic qentry_t classify(input logic [7:0] b);
    qentry_t q;
    q.data = b;
    q.pt   = PT_NONE;
    q.cls  = CL_BAD;
    if (b <= 8'h7f) begin
      q.cls = CL_POSINT;
    end else if (b >= 8'he0) begin
      q.cls = CL_NEGINT;
    end else if (b >= 8'h90 && b <= 8'h9f) begin
      q.cls = CL_ARRFIX;
    end else if (b >= 8'ha0 && b <= 8'hbf) begin
      q.cls = CL_STRFIX;
    end else begin
      case (b)
        8'hc0: q.cls = CL_NIL;
        8'hc2: q.cls = CL_FALSE;
        8'hc3: q.cls = CL_TRUE;
        8'hca: begin q.cls = CL_FLOAT;  q.pt = PT_SINGLE; end
        8'hcb: begin q.cls = CL_FLOAT;  q.pt = PT_DOUBLE; end
        8'hd0: begin q.cls = CL_GATHER; q.pt = PT_INT8;   end
        8'hd1: begin q.cls = CL_GATHER; q.pt = PT_INT16;  end
        8'hd2: begin q.cls = CL_GATHER; q.pt = PT_INT32;  end
        8'hd3: begin q.cls = CL_GATHER; q.pt = PT_INT64;  end
        8'hdc: begin q.cls = CL_GATHER; q.pt = PT_ARR16;  end
        8'hdd: begin q.cls = CL_GATHER; q.pt = PT_ARR32;  end
        8'hd7: begin q.cls = CL_GATHER; q.pt = PT_ARR64;  end
        8'hd9: begin q.cls = CL_GATHER; q.pt = PT_STR8;   end
        8'hda: begin q.cls = CL_GATHER; q.pt = PT_STR16;  end
        8'hdb: begin q.cls = CL_GATHER; q.pt = PT_STR32;  end
        default: q.cls = CL_BAD;
      endcase
    end
    return q;
  endfunction

endpackage

// ----- hw/rtl/ptsd_front.sv -----
// Front stage: accepts stream bytes and classifies each as a type byte.
// Depends on ptsd_pkg.
module ptsd_front import ptsd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic [7:0] byte_in_i,
  output logic    wr_valid_o,
  output qentry_t wr_entry_o,
  input  logic    q_full_i
);

  logic    valid_q, valid_d;
  qentry_t entry_q;
  logic    take;

  assign in_stall_o = valid_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign wr_valid_o = valid_q && !q_full_i;
  assign wr_entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (wr_valid_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= classify(byte_in_i);
    end
  end

endmodule

// ----- hw/rtl/ptsd_queue.sv -----
// Short queue of classified bytes between front and back.
// Depends on ptsd_pkg.
module ptsd_queue import ptsd_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  input  qentry_t wr_entry_i,
  output logic    full_o,
  output logic    rd_valid_o,
  output qentry_t rd_entry_o,
  input  logic    pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  qentry_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign full_o     = cnt_q == CntW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && !full_o;
  assign pop        = pop_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// ----- hw/rtl/ptsd_back.sv -----
// Back stage: decode state machine, field assembly and token output register.
// Depends on ptsd_pkg.
module ptsd_back import ptsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        big_endian_i,
  input  logic        rd_valid_i,
  input  qentry_t     rd_entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [63:0] token_value_o,
  output logic        last_of_run_o,
  output logic        from_single_o
);

  phase_e      phase_q, phase_d;
  ptype_e      pt_q, pt_d;
  logic [3:0]  bl_q, bl_d;
  logic [63:0] asm_q, asm_d;
  logic [63:0] run_q, run_d;
  logic [63:0] lac_q, lac_d;
  logic        after_q, after_d;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q, kind_d;
  logic [63:0] value_q, value_d;
  logic        last_q, last_d;
  logic        single_q, single_d;

  logic        can_emit, emit;
  logic [7:0]  b;
  logic [3:0]  size, bl_cur, bl_new, idx;
  logic [63:0] asm_new;
  logic        run_last;

  assign can_emit = !out_valid_q || !out_stall_i;
  assign pop_o    = rd_valid_i && can_emit;
  assign b        = rd_entry_i.data;
  assign size     = field_size(pt_q);
  assign bl_cur   = (bl_q == 4'd0 || bl_q > size) ? size : bl_q;
  assign idx      = size - bl_cur;
  assign bl_new   = bl_cur - 4'd1;
  assign asm_new  = big_endian_i ? {asm_q[55:0], b}
                                 : asm_q | ({56'd0, b} << {idx[2:0], 3'b000});
  assign run_last = run_q <= 64'd1;

  always_comb begin
    phase_d  = phase_q;
    pt_d     = pt_q;
    bl_d     = bl_q;
    asm_d    = asm_q;
    run_d    = run_q;
    lac_d    = lac_q;
    after_d  = after_q;
    emit     = 1'b0;
    kind_d   = kind_q;
    value_d  = value_q;
    last_d   = 1'b0;
    single_d = 1'b0;
    if (pop_o) begin
      case (phase_q)
        PH_STR: begin
          emit    = 1'b1;
          kind_d  = TK_STR_BYTE;
          value_d = {56'd0, b};
          last_d  = run_last;
          run_d   = run_last ? 64'd0 : run_q - 64'd1;
          if (run_last) begin
            phase_d = PH_IDLE;
          end
        end
        PH_GATHER, PH_ELEM: begin
          asm_d = asm_new;
          bl_d  = bl_new;
          if (bl_new == 4'd0) begin
            emit = 1'b1;
            if (phase_q == PH_ELEM) begin
              kind_d   = TK_ELEMENT;
              single_d = pt_q == PT_SINGLE;
              value_d  = (pt_q == PT_SINGLE) ? widen_single(asm_new[31:0]) : asm_new;
              last_d   = run_last;
              run_d    = run_last ? 64'd0 : run_q - 64'd1;
              if (run_last) begin
                phase_d = PH_IDLE;
              end else begin
                bl_d  = size;
                asm_d = 64'd0;
              end
            end else begin
              phase_d = PH_IDLE;
              if (pt_q inside {PT_INT8, PT_INT16, PT_INT32, PT_INT64}) begin
                kind_d  = TK_INT;
                value_d = sign_extend(asm_new, size);
              end else if (pt_q inside {PT_ARR16, PT_ARR32, PT_ARR64}) begin
                kind_d  = TK_ARR_HDR;
                value_d = asm_new;
                if (asm_new != 64'd0) begin
                  after_d = 1'b1;
                  lac_d   = asm_new;
                end
              end else begin
                kind_d  = TK_STR_HDR;
                value_d = asm_new;
                if (asm_new != 64'd0) begin
                  phase_d = PH_STR;
                  run_d   = asm_new;
                end
              end
            end
          end
        end
        default: begin
          after_d = 1'b0;
          value_d = {56'd0, b};
          case (rd_entry_i.cls)
            CL_FLOAT: begin
              if (!after_q) begin
                emit   = 1'b1;
                kind_d = TK_MISFLOAT;
              end else begin
                run_d   = lac_q;
                pt_d    = rd_entry_i.pt;
                phase_d = PH_ELEM;
                bl_d    = field_size(rd_entry_i.pt);
                asm_d   = 64'd0;
              end
            end
            CL_POSINT: begin
              emit   = 1'b1;
              kind_d = TK_INT;
            end
            CL_NEGINT: begin
              emit    = 1'b1;
              kind_d  = TK_INT;
              value_d = {56'hff_ffff_ffff_ffff, b};
            end
            CL_ARRFIX: begin
              emit    = 1'b1;
              kind_d  = TK_ARR_HDR;
              value_d = {60'd0, b[3:0]};
              if (b[3:0] != 4'd0) begin
                after_d = 1'b1;
                lac_d   = {60'd0, b[3:0]};
              end
            end
            CL_STRFIX: begin
              emit    = 1'b1;
              kind_d  = TK_STR_HDR;
              value_d = {59'd0, b[4:0]};
              if (b[4:0] != 5'd0) begin
                phase_d = PH_STR;
                run_d   = {59'd0, b[4:0]};
              end
            end
            CL_NIL: begin
              emit    = 1'b1;
              kind_d  = TK_NIL;
              value_d = 64'd0;
            end
            CL_FALSE: begin
              emit    = 1'b1;
              kind_d  = TK_BOOL;
              value_d = 64'd0;
            end
            CL_TRUE: begin
              emit    = 1'b1;
              kind_d  = TK_BOOL;
              value_d = 64'd1;
            end
            CL_GATHER: begin
              pt_d    = rd_entry_i.pt;
              phase_d = PH_GATHER;
              bl_d    = field_size(rd_entry_i.pt);
              asm_d   = 64'd0;
            end
            default: begin
              emit   = 1'b1;
              kind_d = TK_BAD_TYPE;
            end
          endcase
        end
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pt_q        <= PT_NONE;
      bl_q        <= 4'd0;
      asm_q       <= 64'd0;
      run_q       <= 64'd0;
      lac_q       <= 64'd0;
      after_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pt_q        <= pt_d;
      bl_q        <= bl_d;
      asm_q       <= asm_d;
      run_q       <= run_d;
      lac_q       <= lac_d;
      after_q     <= after_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= kind_d;
      value_q  <= value_d;
      last_q   <= last_d;
      single_q <= single_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign token_value_o = value_q;
  assign last_of_run_o = last_q;
  assign from_single_o = single_q;

endmodule

// ----- hw/rtl/packed_token_stream_decoder.sv -----
// Top level of the packed token stream decoder: configuration register,
// front classifier, byte queue and back decoder. Depends on ptsd_pkg.
//
// Input channel: one stream byte per transfer (in_valid_i, in_stall_o,
// byte_in_i). Output channel: one token per transfer (out_valid_o,
// out_stall_i, token_kind_o, token_value_o, last_of_run_o, from_single_o).
// Bytes that only feed a length, integer or element field give no token.
// Throughput is one byte per cycle while in_stall_o is low; the back
// decoder consumes one queued byte each cycle its output register is
// free or being drained. The byte that completes a token passes the front
// register, then the queue, then the output register.
// A receiver stall holds the token register; the queue of QueueDepth
// entries and the front register absorb bytes until in_stall_o rises.
// Reset empties the pipeline, returns the decoder to awaiting a type byte
// and selects little-endian byte order. The APB register at offset 0
// (bit 0) selects big-endian order; write it while the stream is idle.
module packed_token_stream_decoder import ptsd_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [63:0] token_value_o,
  output logic        last_of_run_o,
  output logic        from_single_o
);

  logic    big_endian_q, big_endian_d;
  logic    wr_valid, q_full, rd_valid, pop;
  qentry_t wr_entry, rd_entry;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, big_endian_q} : 32'd0;

  always_comb begin
    big_endian_d = big_endian_q;
    if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      big_endian_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else begin
      big_endian_q <= big_endian_d;
    end
  end

  ptsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .byte_in_i  (byte_in_i),
    .wr_valid_o (wr_valid),
    .wr_entry_o (wr_entry),
    .q_full_i   (q_full)
  );

  ptsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_entry_i (wr_entry),
    .full_o     (q_full),
    .rd_valid_o (rd_valid),
    .rd_entry_o (rd_entry),
    .pop_i      (pop)
  );

  ptsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .big_endian_i  (big_endian_q),
    .rd_valid_i    (rd_valid),
    .rd_entry_i    (rd_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .last_of_run_o (last_of_run_o),
    .from_single_o (from_single_o)
  );

endmodule
